// ===== src/reply_frame_checker_defines.svh =====
// ----------------------------------------------------------------------------
// reply frame checker assertion macros
// shared assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_CHECKER_DEFINES_SVH
`define REPLY_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTH

// checked only outside reset
`define RFC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("reply_frame_checker assertion failed");

// checked on every edge, reset included
`define RFC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("reply_frame_checker assertion failed");

`else

`define RFC_ASSERT(label, prop)
`define RFC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== src/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// types and constants of the reply frame checker
// ----------------------------------------------------------------------------
package rfc_pkg;

   localparam int MAX_DATA   = 64;
   localparam int HEADER_LEN = 3;                      // marker, status, length
   localparam int FRAME_CAP  = MAX_DATA + HEADER_LEN + 1;
   localparam int POS_W      = $clog2(FRAME_CAP + 1);

   localparam int BYTE_W     = 8;
   localparam int LIMIT_W    = 7;
   localparam int COUNT_W    = 7;
   localparam int LEN_SUM_W  = BYTE_W + 1;

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic CSR_START_MARKER = 1'b0;
   localparam logic CSR_LENGTH_LIMIT = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_TOO_SHORT  = 3'd1,
      VERDICT_BAD_MARKER = 3'd2,
      VERDICT_TOO_LONG   = 3'd3,
      VERDICT_INCOMPLETE = 3'd4,
      VERDICT_BAD_SUM    = 3'd5
   } verdict_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      verdict_type         verdict;
      logic [BYTE_W-1:0]   status;
      logic [COUNT_W-1:0]  count;
   } word_type;

endpackage

// ===== src/reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// reply_frame_checker
// checks a reply frame (marker, status, length, data, xor checksum) byte by byte
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Frame state is updated in the accepting
// cycle and the resulting words (a tentative data byte, a verdict, or both on
// the last byte) go into a four-word output queue that drains one word per
// cycle while rsp_ready is high. A byte is accepted whenever at least two
// queue slots are free, so a stream of bytes runs at one byte per cycle while
// the consumer keeps up; a byte that carries both a data word and a verdict
// takes two slots in the queue.
`include "reply_frame_checker_defines.svh"

module reply_frame_checker
   import rfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [BYTE_W-1:0]  csr_wdata,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   input  logic               req_end_of_reply,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_kind,
   output logic [BYTE_W-1:0]  rsp_data_byte,
   output logic [2:0]         rsp_verdict,
   output logic [BYTE_W-1:0]  rsp_reply_status,
   output logic [COUNT_W-1:0] rsp_byte_count
);

   // configuration
   logic [BYTE_W-1:0]  start_marker_ff;
   logic [LIMIT_W-1:0] length_limit_ff;

   // frame state
   logic [POS_W-1:0]   byte_pos_ff,   byte_pos_in;
   logic [BYTE_W-1:0]  marker_ff,     marker_in;
   logic [BYTE_W-1:0]  status_ff,     status_in;
   logic [BYTE_W-1:0]  length_ff,     length_in;
   logic [BYTE_W-1:0]  xor_ff,        xor_in;
   logic [BYTE_W-1:0]  checksum_ff,   checksum_in;

   // output queue
   word_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;

   logic               accept;
   logic               pop;
   logic [1:0]         push_cnt;
   word_type           word0, word1;
   logic [BYTE_W-1:0]  eff_limit;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign eff_limit = ({1'b0, length_limit_ff} > BYTE_W'(MAX_DATA)) ?
                      BYTE_W'(MAX_DATA) : {1'b0, length_limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
         length_limit_ff <= LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // frame update and word build
   always_comb begin
      logic [LEN_SUM_W-1:0] pos_wide;
      logic [LEN_SUM_W-1:0] data_end;
      logic                 data_byte;
      logic                 pass_on;
      verdict_type          verdict;

      pos_wide    = LEN_SUM_W'(byte_pos_ff);
      data_end    = {1'b0, length_ff} + LEN_SUM_W'(HEADER_LEN);
      data_byte   = 1'b0;
      byte_pos_in = byte_pos_ff;
      marker_in   = marker_ff;
      status_in   = status_ff;
      length_in   = length_ff;
      xor_in      = xor_ff;
      checksum_in = checksum_ff;

      if (byte_pos_ff < POS_W'(FRAME_CAP)) begin
         priority if (byte_pos_ff == POS_W'(0)) begin
            marker_in = req_rx_byte;
            xor_in    = xor_ff ^ req_rx_byte;
         end else if (byte_pos_ff == POS_W'(1)) begin
            status_in = req_rx_byte;
            xor_in    = xor_ff ^ req_rx_byte;
         end else if (byte_pos_ff == POS_W'(2)) begin
            length_in = req_rx_byte;
            xor_in    = xor_ff ^ req_rx_byte;
         end else if (pos_wide < data_end) begin
            xor_in    = xor_ff ^ req_rx_byte;
            data_byte = 1'b1;
         end else if (pos_wide == data_end) begin
            checksum_in = req_rx_byte;
         end else begin
         end
         byte_pos_in = byte_pos_ff + POS_W'(1);
      end

      pass_on = data_byte && (marker_ff == start_marker_ff) && (length_ff <= eff_limit);

      // verdict from the state as it stands after this byte
      priority if (byte_pos_in < POS_W'(HEADER_LEN + 1))
         verdict = VERDICT_TOO_SHORT;
      else if (marker_in != start_marker_ff)
         verdict = VERDICT_BAD_MARKER;
      else if (length_in > eff_limit)
         verdict = VERDICT_TOO_LONG;
      else if (LEN_SUM_W'(byte_pos_in) < ({1'b0, length_in} + LEN_SUM_W'(HEADER_LEN + 1)))
         verdict = VERDICT_INCOMPLETE;
      else if (xor_in != checksum_in)
         verdict = VERDICT_BAD_SUM;
      else
         verdict = VERDICT_OK;

      word1         = '0;
      word1.kind    = KIND_VERDICT;
      word1.verdict = verdict;
      word1.status  = status_in;
      word1.count   = (verdict == VERDICT_OK) ? length_in[COUNT_W-1:0] : '0;

      word0      = '0;
      word0.kind = KIND_DATA;
      word0.data = req_rx_byte;

      push_cnt = 2'd0;
      if (accept) begin
         if (pass_on && req_end_of_reply)
            push_cnt = 2'd2;
         else if (pass_on)
            push_cnt = 2'd1;
         else if (req_end_of_reply) begin
            push_cnt = 2'd1;
            word0    = word1;
         end
      end

      if (req_end_of_reply) begin
         byte_pos_in = '0;
         marker_in   = '0;
         status_in   = '0;
         length_in   = '0;
         xor_in      = '0;
         checksum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         marker_ff   <= '0;
         status_ff   <= '0;
         length_ff   <= '0;
         xor_ff      <= '0;
         checksum_ff <= '0;
      end else if (accept) begin
         byte_pos_ff <= byte_pos_in;
         marker_ff   <= marker_in;
         status_ff   <= status_in;
         length_ff   <= length_in;
         xor_ff      <= xor_in;
         checksum_ff <= checksum_in;
      end
   end

   // queue pointers
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_cnt != 2'd0 && QPTR_W'(i) == wr_ptr_ff)
            queue_ff[i] <= word0;
         else if (push_cnt == 2'd2 && QPTR_W'(i) == wr_ptr_ff + QPTR_W'(1))
            queue_ff[i] <= word1;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_result_kind  = queue_ff[rd_ptr_ff].kind;
   assign rsp_data_byte    = queue_ff[rd_ptr_ff].data;
   assign rsp_verdict      = queue_ff[rd_ptr_ff].verdict;
   assign rsp_reply_status = queue_ff[rd_ptr_ff].status;
   assign rsp_byte_count   = queue_ff[rd_ptr_ff].count;

   `RFC_ASSERT(a_queue_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `RFC_ASSERT(a_pos_saturates, byte_pos_ff <= POS_W'(FRAME_CAP))
   `RFC_ASSERT(a_end_clears, (accept && req_end_of_reply) |=> (byte_pos_ff == '0 && xor_ff == '0))
   `RFC_ASSERT(a_ok_count_bound, (rsp_valid && rsp_result_kind == KIND_VERDICT && rsp_verdict == VERDICT_OK) |-> (rsp_byte_count <= COUNT_W'(MAX_DATA)))
   `RFC_ASSERT_ALWAYS(a_reset_empties, reset |=> (count_ff == '0 && !rsp_valid))

endmodule

// ===== dv/reply_frame_checker_tb.sv =====
// ----------------------------------------------------------------------------
// reply_frame_checker_tb
// drives reply frames byte by byte and checks every data word and verdict
// ----------------------------------------------------------------------------
// A frame tracker in the bench follows the marker, status, length, data and
// checksum bytes under the current register values and queues the words the
// block owes. Directed frames cover each verdict, trailing bytes and the limit
// corner cases; random frames, mostly well formed, run under several register
// settings with random gaps and stalls on both channels.
`timescale 1ns / 100ps

module reply_frame_checker_tb;
   import rfc_pkg::*;

   localparam int RANDOM_ITEMS   = 1600;
   localparam int PHASES         = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 200;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic               csr_index;
   logic [BYTE_W-1:0]  csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_rx_byte;
   logic               req_end_of_reply;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_result_kind;
   logic [BYTE_W-1:0]  rsp_data_byte;
   logic [2:0]         rsp_verdict;
   logic [BYTE_W-1:0]  rsp_reply_status;
   logic [COUNT_W-1:0] rsp_byte_count;

   reply_frame_checker dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_end_of_reply (req_end_of_reply),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_verdict      (rsp_verdict),
      .rsp_reply_status (rsp_reply_status),
      .rsp_byte_count   (rsp_byte_count)
   );

   // register copies and frame state of the tracker
   logic [BYTE_W-1:0]  cfg_marker;
   logic [LIMIT_W-1:0] cfg_limit;
   int                 frame_pos;
   logic [BYTE_W-1:0]  got_marker;
   logic [BYTE_W-1:0]  got_status;
   logic [BYTE_W-1:0]  got_length;
   logic [BYTE_W-1:0]  xor_sum;
   logic [BYTE_W-1:0]  got_checksum;

   word_type          words_due[$];
   logic [BYTE_W-1:0] frame_buf[$];
   int                error_count = 0;
   int                items_sent = 0;
   int                rsp_hold_request = 0;
   bit                sender_gaps_on = 1'b1;
   bit                rsp_stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      else if (r < 95) return $urandom_range(3, 10);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int effective_limit();
      return (int'(cfg_limit) > MAX_DATA) ? MAX_DATA : int'(cfg_limit);
   endfunction

   task automatic clear_frame();
      frame_pos = 0;
      got_marker = '0;
      got_status = '0;
      got_length = '0;
      xor_sum = '0;
      got_checksum = '0;
   endtask

   // one accepted byte: update the frame and queue the words it owes
   task automatic advance_frame(input logic [BYTE_W-1:0] b, input logic last);
      word_type w;
      int       len;
      len = int'(got_length);
      if (frame_pos < FRAME_CAP) begin
         if (frame_pos == 0) begin
            got_marker = b;
            xor_sum ^= b;
         end else if (frame_pos == 1) begin
            got_status = b;
            xor_sum ^= b;
         end else if (frame_pos == 2) begin
            got_length = b;
            xor_sum ^= b;
         end else if (frame_pos < 3 + len) begin
            xor_sum ^= b;
            if (got_marker == cfg_marker && len <= effective_limit()) begin
               w = '0;
               w.kind = KIND_DATA;
               w.verdict = VERDICT_OK;
               w.data = b;
               words_due.push_back(w);
            end
         end else if (frame_pos == 3 + len) begin
            got_checksum = b;
         end
         frame_pos++;
      end
      if (last) begin
         w = '0;
         w.kind = KIND_VERDICT;
         w.status = got_status;
         if (frame_pos < 4) w.verdict = VERDICT_TOO_SHORT;
         else if (got_marker != cfg_marker) w.verdict = VERDICT_BAD_MARKER;
         else if (int'(got_length) > effective_limit()) w.verdict = VERDICT_TOO_LONG;
         else if (frame_pos < 4 + int'(got_length)) w.verdict = VERDICT_INCOMPLETE;
         else if (xor_sum != got_checksum) w.verdict = VERDICT_BAD_SUM;
         else begin
            w.verdict = VERDICT_OK;
            w.count = got_length[COUNT_W-1:0];
         end
         words_due.push_back(w);
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // tracker and result check, both sampled at the same edge
   always @(posedge clock) begin
      word_type want;
      if (reset) begin
         cfg_marker = '0;
         cfg_limit = LIMIT_RESET;
         clear_frame();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_START_MARKER) cfg_marker = csr_wdata;
            else cfg_limit = csr_wdata[LIMIT_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               $error("unexpected word: kind %0d data %0d verdict %0d", rsp_result_kind,
                      rsp_data_byte, rsp_verdict);
               error_count++;
            end else begin
               want = words_due.pop_front();
               check_field("result_kind", BYTE_W'(want.kind), BYTE_W'(rsp_result_kind));
               check_field("data_byte", want.data, rsp_data_byte);
               check_field("verdict", BYTE_W'(want.verdict), BYTE_W'(rsp_verdict));
               check_field("reply_status", want.status, rsp_reply_status);
               check_field("byte_count", BYTE_W'(want.count), BYTE_W'(rsp_byte_count));
            end
         end
         if (req_valid && req_ready) advance_frame(req_rx_byte, req_end_of_reply);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // valid stays up across back-to-back words, drops only for a gap
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_end_of_reply <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      if (sender_gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // fill < 0 gives random data bytes
   task automatic build_frame(input logic [BYTE_W-1:0] mk, input logic [BYTE_W-1:0] st,
                              input int len, input int fill, input logic [BYTE_W-1:0] sum_flip);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] d;
      frame_buf.delete();
      frame_buf.push_back(mk);
      frame_buf.push_back(st);
      frame_buf.push_back(len[7:0]);
      sum = mk ^ st ^ len[7:0];
      for (int i = 0; i < len; i++) begin
         if (fill < 0) d = BYTE_W'($urandom_range(0, 255));
         else d = fill[7:0];
         frame_buf.push_back(d);
         sum ^= d;
      end
      frame_buf.push_back(sum ^ sum_flip);
   endtask

   task automatic keep_first(input int n);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [BYTE_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // reset values: marker 0, limit 64; trailing bytes after the checksum
   task automatic test_reset_values();
      build_frame(8'h00, 8'hFF, 1, 255, 8'h00);
      frame_buf.push_back(8'h00);
      frame_buf.push_back(8'hFF);
      send_frame();
   endtask

   task automatic test_verdict_order();
      // marker alone
      build_frame(8'h00, 8'h12, 0, -1, 8'h00);
      keep_first(1);
      send_frame();
      // wrong marker holds back its data word
      build_frame(8'h01, 8'h34, 1, -1, 8'h00);
      send_frame();
      // length over limit wins over incomplete
      build_frame(8'h00, 8'h56, 65, -1, 8'h00);
      keep_first(4);
      send_frame();
      // ends on a data byte: data word, then the verdict
      build_frame(8'h00, 8'h78, 2, 0, 8'h00);
      keep_first(4);
      send_frame();
      build_frame(8'h00, 8'h9A, 0, -1, 8'h80);
      send_frame();
   endtask

   task automatic test_limit_settings();
      wait_for_drain();
      write_csr(CSR_START_MARKER, 8'hFF);
      write_csr(CSR_LENGTH_LIMIT, 8'd0);
      build_frame(8'hFF, 8'h01, 0, -1, 8'h00);
      send_frame();
      build_frame(8'hFF, 8'h02, 1, -1, 8'h00);
      keep_first(4);
      send_frame();
      wait_for_drain();
      // limit above the data capacity is clamped
      write_csr(CSR_LENGTH_LIMIT, 8'd127);
      build_frame(8'hFF, 8'h03, 65, -1, 8'h00);
      keep_first(4);
      send_frame();
   endtask

   task automatic test_back_pressure();
      logic [BYTE_W-1:0] st;
      wait_for_drain();
      sender_gaps_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      repeat (5) begin
         st = BYTE_W'($urandom_range(0, 255));
         build_frame(cfg_marker, st, 6, -1, 8'h00);
         send_frame();
      end
      sender_gaps_on = 1'b1;
      wait_for_drain();
   endtask

   task automatic send_random_reply();
      int                r;
      int                lim;
      int                len;
      logic [BYTE_W-1:0] st;
      logic [BYTE_W-1:0] flip;
      logic [BYTE_W-1:0] d;
      lim = effective_limit();
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(0, (lim < 6) ? lim : 6);
      else if (r < 9) len = $urandom_range(0, lim);
      else len = lim;
      st = BYTE_W'($urandom_range(0, 255));
      flip = BYTE_W'($urandom_range(1, 255));
      r = $urandom_range(0, 99);
      if (r < 60) begin
         build_frame(cfg_marker, st, len, -1, 8'h00);
      end else if (r < 68) begin
         build_frame(cfg_marker ^ flip, st, len, -1, 8'h00);
      end else if (r < 75) begin
         // over the limit, sometimes long enough to run past the position cap
         build_frame(cfg_marker, st, $urandom_range(lim + 1, 255), -1, 8'h00);
         keep_first($urandom_range(3, 80));
      end else if (r < 82) begin
         build_frame(cfg_marker, st, len, -1, 8'h00);
         keep_first($urandom_range(1, frame_buf.size() - 1));
      end else if (r < 89) begin
         build_frame(cfg_marker, st, len, -1, flip);
      end else if (r < 95) begin
         build_frame(cfg_marker, st, len, -1, 8'h00);
         repeat ($urandom_range(1, 8)) begin
            d = BYTE_W'($urandom_range(0, 255));
            frame_buf.push_back(d);
         end
      end else begin
         frame_buf.delete();
         repeat ($urandom_range(1, 12)) begin
            d = BYTE_W'($urandom_range(0, 255));
            frame_buf.push_back(d);
         end
      end
      send_frame();
   endtask

   task automatic test_random_replies();
      logic [BYTE_W-1:0] mk;
      logic [BYTE_W-1:0] lw;
      int                phase_start;
      for (int phase = 0; phase < PHASES; phase++) begin
         mk = BYTE_W'($urandom_range(0, 255));
         lw = BYTE_W'($urandom_range(1, 64));
         case (phase)
            0: begin
               mk = 8'hA5;
               lw = 8'd64;
            end
            1: begin
               mk = 8'h00;
               lw = 8'd1;
            end
            2: begin
               mk = 8'hFF;
               lw = 8'd127;
            end
            3: lw = 8'd0;
            5: lw = lw | 8'h80;     // top write bit is not part of the limit
            default: ;
         endcase
         wait_for_drain();
         write_csr(CSR_START_MARKER, mk);
         write_csr(CSR_LENGTH_LIMIT, lw);
         sender_gaps_on = (phase % 4) < 2;
         rsp_stalls_on = (phase % 4) == 0 || (phase % 4) == 2;
         phase_start = items_sent;
         while (items_sent < phase_start + RANDOM_ITEMS / PHASES) send_random_reply();
      end
      sender_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      req_end_of_reply <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_START_MARKER;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_verdict_order();
      test_limit_settings();
      test_back_pressure();
      test_random_replies();
      wait_for_drain();
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
